// ===== hdl/srr_pkg.sv =====
// ============================================================================
// srr_pkg
// Shared types, codes and sizes of the selective-reject receiver.
// ============================================================================
`default_nettype none

package srr_pkg;

    // Buffer geometry
    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int WIN_W        = SLOT_W + 1;

    // Field widths
    localparam int SEQ_W      = 32;
    localparam int KIND_W     = 3;
    localparam int CMD_W      = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int WSIZE_W    = 5;
    localparam int TLIM_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Result limits
    localparam int MAX_RESULTS = 32;
    localparam int DRAIN_MAX   = (MAX_RESULTS - 2) / 2;
    localparam int DRAIN_W     = $clog2(DRAIN_MAX + 1);
    localparam int EOF_REPEAT  = 3;
    localparam int EOF_W       = $clog2(EOF_REPEAT);

    // Register reset values
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(16);
    localparam logic [TLIM_W-1:0]  TLIM_RESET  = TLIM_W'(15);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 1'b1;

    // Input codes
    localparam logic ACTION_PACKET  = 1'b0;
    localparam logic ACTION_TIMEOUT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_DATA           = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SREJ_RESEND    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT_RESEND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EOF            = 3'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RR         = 3'd0,
        CMD_SREJ       = 3'd1,
        CMD_WRITE_IN   = 3'd2,
        CMD_WRITE_SLOT = 3'd3,
        CMD_STORE      = 3'd4,
        CMD_FINISHED   = 3'd5
    } command_t;

    typedef struct packed {
        logic              action;
        logic [SEQ_W-1:0]  pkt_seq;
        logic [KIND_W-1:0] pkt_kind;
        logic              checksum_good;
        logic              has_payload;
    } in_item_t;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [SEQ_W-1:0]      ack_seq;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  last;
    } out_item_t;

    typedef enum logic [2:0] {
        ACK_ITEM_SEQ,
        ACK_EXPECTED,
        ACK_EXP_MINUS1,
        ACK_EOF,
        ACK_HIGHEST,
        ACK_HIGHEST_PLUS1,
        ACK_ZERO
    } ack_sel_t;

    typedef enum logic [1:0] {
        SLOT_NONE,
        SLOT_STORE,
        SLOT_EXPECTED
    } slot_sel_t;

    typedef enum logic [1:0] {
        PKT_DATA,
        PKT_EOF,
        PKT_OTHER
    } pkt_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACK,
        ST_DRAIN,
        ST_SREJ,
        ST_EOF_RR,
        ST_TO_SREJ,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic      emit;
        command_t  res_cmd;
        ack_sel_t  ack_sel;
        slot_sel_t slot_sel;
        logic      last;
        logic      latch_item;
        logic      clr_timeout;
        logic      inc_timeout;
        logic      upd_highest;
        logic      release_slot;
        logic      store_slot;
        logic      exp_inc;
        logic      drain_clr;
        logic      drain_inc;
        logic      eof_clr;
        logic      eof_inc;
        logic      set_eof;
        logic      set_done;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       done;
        logic       eof_seen;
        logic       action;
        logic       good;
        pkt_class_t pkt_class;
        logic       seq_eq;
        logic       seq_gt;
        logic       in_window;
        logic       has_payload;
        logic       to_reach;
        logic       drain_hit;
        logic       eof_last;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/selective_reject_receiver_unit.sv =====
// ============================================================================
// selective_reject_receiver_unit
// Command generator for the receiving end of a selective-reject transfer.
// ============================================================================
// The item is latched on transfer, evaluated in ST_EVAL and its first command
// registered into the result register (an EOF without payload gives its first
// from ST_EOF_RR); the rest follow one per cycle while the output is free.
// A new item is taken only once the unit is back in ST_IDLE.
// Reset clears all control state, the slot valid bits and the registers; the
// tag memory is not cleared and needs no clearing pass.
`default_nettype none

module selective_reject_receiver_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire srr_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output srr_pkg::out_item_t                   out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [srr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [srr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import srr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    srr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    srr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== hdl/srr_ram.sv =====
// ============================================================================
// srr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module srr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/srr_ctrl.sv =====
// ============================================================================
// srr_ctrl
// Sequencer that walks each item through its commands, one per cycle while the output is free.
// ============================================================================
`default_nettype none

module srr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire srr_pkg::dp_status_t status,
    output srr_pkg::ctrl_cmd_t       cmd
);

    import srr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.out_free)
                begin
                    if (status.done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.action == ACTION_TIMEOUT)
                    begin
                        if (status.eof_seen)
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (status.to_reach)
                        begin
                            state_next = ST_TO_SREJ;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else if (!status.good)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        case (status.pkt_class)
                            PKT_DATA:
                            begin
                                if (status.seq_eq)
                                begin
                                    state_next = ST_ACK;
                                end
                                else if (status.seq_gt && status.in_window)
                                begin
                                    state_next = ST_SREJ;
                                end
                                else
                                begin
                                    state_next = ST_IDLE;
                                end
                            end
                            PKT_EOF:
                            begin
                                state_next = ST_EOF_RR;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_ACK:
            begin
                if (status.out_free)
                begin
                    state_next = status.drain_hit ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ACK;
                end
            end
            ST_SREJ:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EOF_RR:
            begin
                if (status.out_free && status.eof_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_TO_SREJ:
            begin
                if (status.out_free)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_item = in_valid;
            end
            ST_EVAL:
            begin
                if (status.out_free && !status.done)
                begin
                    if (status.action == ACTION_TIMEOUT)
                    begin
                        if (!status.eof_seen)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.res_cmd     = CMD_RR;
                            cmd.ack_sel     = ACK_HIGHEST;
                            cmd.last        = !status.to_reach;
                            cmd.inc_timeout = 1'b1;
                        end
                    end
                    else if (!status.good)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.res_cmd = CMD_SREJ;
                        cmd.ack_sel = ACK_EXPECTED;
                        cmd.last    = 1'b1;
                    end
                    else
                    begin
                        cmd.clr_timeout = 1'b1;
                        cmd.upd_highest = 1'b1;
                        case (status.pkt_class)
                            PKT_DATA:
                            begin
                                cmd.emit = 1'b1;
                                if (status.seq_eq)
                                begin
                                    cmd.res_cmd      = CMD_WRITE_IN;
                                    cmd.ack_sel      = ACK_ITEM_SEQ;
                                    cmd.release_slot = 1'b1;
                                    cmd.exp_inc      = 1'b1;
                                    cmd.drain_clr    = 1'b1;
                                end
                                else if (status.seq_gt && status.in_window)
                                begin
                                    cmd.res_cmd    = CMD_STORE;
                                    cmd.ack_sel    = ACK_ITEM_SEQ;
                                    cmd.slot_sel   = SLOT_STORE;
                                    cmd.store_slot = 1'b1;
                                end
                                else if (status.seq_gt)
                                begin
                                    cmd.res_cmd = CMD_SREJ;
                                    cmd.ack_sel = ACK_EXPECTED;
                                    cmd.last    = 1'b1;
                                end
                                else
                                begin
                                    // Duplicate of an already delivered packet.
                                    cmd.res_cmd = CMD_RR;
                                    cmd.ack_sel = ACK_EXP_MINUS1;
                                    cmd.last    = 1'b1;
                                end
                            end
                            PKT_EOF:
                            begin
                                cmd.emit    = status.has_payload;
                                cmd.res_cmd = CMD_WRITE_IN;
                                cmd.ack_sel = ACK_ITEM_SEQ;
                                cmd.eof_clr = 1'b1;
                            end
                            default:
                            begin
                                cmd.emit = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_ACK:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_cmd = CMD_RR;
                    cmd.ack_sel = ACK_EXP_MINUS1;
                    cmd.last    = !status.drain_hit;
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit         = 1'b1;
                    cmd.res_cmd      = CMD_WRITE_SLOT;
                    cmd.ack_sel      = ACK_EXPECTED;
                    cmd.slot_sel     = SLOT_EXPECTED;
                    cmd.release_slot = 1'b1;
                    cmd.exp_inc      = 1'b1;
                    cmd.drain_inc    = 1'b1;
                end
            end
            ST_SREJ:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_cmd = CMD_SREJ;
                    cmd.ack_sel = ACK_EXPECTED;
                    cmd.last    = 1'b1;
                end
            end
            ST_EOF_RR:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_cmd = CMD_RR;
                    cmd.ack_sel = ACK_EOF;
                    cmd.eof_inc = 1'b1;
                    cmd.set_eof = status.eof_last;
                end
            end
            ST_TO_SREJ:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_cmd = CMD_SREJ;
                    cmd.ack_sel = ACK_HIGHEST_PLUS1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.res_cmd  = CMD_FINISHED;
                    cmd.ack_sel  = ACK_ZERO;
                    cmd.last     = 1'b1;
                    cmd.set_done = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/srr_datapath.sv =====
// ============================================================================
// srr_datapath
// Receiver state, slot buffer bookkeeping, configuration and result register.
// ============================================================================
`default_nettype none

module srr_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire srr_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output srr_pkg::out_item_t                   out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [srr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [srr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire srr_pkg::ctrl_cmd_t              cmd,
    output srr_pkg::dp_status_t                  status
);

    import srr_pkg::*;

    in_item_t                item_reg;
    logic [SEQ_W-1:0]        expected_reg, expected_next;
    logic [SLOT_W-1:0]       exp_slot_reg, exp_slot_next;
    logic [SEQ_W-1:0]        highest_reg, highest_next;
    logic                    eof_seen_reg, eof_seen_next;
    logic                    done_reg, done_next;
    logic [TLIM_W-1:0]       tcount_reg, tcount_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [DRAIN_W-1:0]      drain_cnt_reg, drain_cnt_next;
    logic [EOF_W-1:0]        eof_cnt_reg, eof_cnt_next;
    logic [WSIZE_W-1:0]      wsize_reg, wsize_next;
    logic [TLIM_W-1:0]       tlim_reg, tlim_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg;

    logic [SEQ_W-1:0]  tag_q;
    logic              tag_hit;
    logic [SEQ_W-1:0]  diff;
    logic [WIN_W-1:0]  win_val;
    logic [WIN_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] slot_store;
    logic [SLOT_W-1:0] exp_slot_inc;
    logic [TLIM_W-1:0] tcount_inc;
    logic [SEQ_W-1:0]  eof_ack;
    logic              out_free;
    logic              cfg_wr;
    out_item_t         result;

    // Tags of buffered packets; read address tracks the slot of the expected
    // sequence number so that the registered read data belongs to the current
    // expected_reg.
    srr_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.store_slot),
        .wr_addr (slot_store),
        .wr_data (item_reg.pkt_seq),
        .rd_addr (exp_slot_next),
        .rd_data (tag_q)
    );

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign tag_hit   = valid_reg[exp_slot_reg] && (tag_q == expected_reg);

    // Window clamped to 1..WINDOW_DEPTH.
    always_comb
    begin
        if (wsize_reg == '0)
        begin
            win_val = WIN_W'(1);
        end
        else if (int'(wsize_reg) > WINDOW_DEPTH)
        begin
            win_val = WIN_W'(WINDOW_DEPTH);
        end
        else
        begin
            win_val = WIN_W'(wsize_reg);
        end
    end

    assign diff = item_reg.pkt_seq - expected_reg;

    // Inside the window the distance is at most WINDOW_DEPTH, so one
    // conditional subtract folds the slot back into range.
    assign slot_sum   = WIN_W'(exp_slot_reg) + WIN_W'(diff);
    assign slot_store = (slot_sum >= WIN_W'(WINDOW_DEPTH)) ?
                        SLOT_W'(slot_sum - WIN_W'(WINDOW_DEPTH)) : SLOT_W'(slot_sum);

    // The slot restarts at zero when the sequence number wraps.
    assign exp_slot_inc = (expected_reg == '1) ? '0 :
                          (exp_slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 :
                          exp_slot_reg + SLOT_W'(1);

    assign tcount_inc = (tcount_reg == '1) ? tcount_reg : tcount_reg + TLIM_W'(1);
    assign eof_ack    = (expected_reg == '0) ? '0 : expected_reg - SEQ_W'(1);

    // Status
    always_comb
    begin
        status             = '0;
        status.done        = done_reg;
        status.eof_seen    = eof_seen_reg;
        status.action      = item_reg.action;
        status.good        = item_reg.checksum_good;
        status.seq_eq      = (item_reg.pkt_seq == expected_reg);
        status.seq_gt      = (item_reg.pkt_seq > expected_reg);
        status.in_window   = (diff <= SEQ_W'(win_val));
        status.has_payload = item_reg.has_payload;
        status.to_reach    = (tcount_inc >= tlim_reg);
        status.drain_hit   = tag_hit && (int'(drain_cnt_reg) < DRAIN_MAX);
        status.eof_last    = (int'(eof_cnt_reg) == EOF_REPEAT - 1);
        status.out_free    = out_free;
        case (item_reg.pkt_kind) inside
            [KIND_DATA:KIND_TIMEOUT_RESEND]: status.pkt_class = PKT_DATA;
            KIND_EOF:                        status.pkt_class = PKT_EOF;
            default:                         status.pkt_class = PKT_OTHER;
        endcase
    end

    // Result fields
    always_comb
    begin
        result         = '0;
        result.command = cmd.res_cmd;
        result.last    = cmd.last;
        case (cmd.ack_sel)
            ACK_ITEM_SEQ:      result.ack_seq = item_reg.pkt_seq;
            ACK_EXPECTED:      result.ack_seq = expected_reg;
            ACK_EXP_MINUS1:    result.ack_seq = expected_reg - SEQ_W'(1);
            ACK_EOF:           result.ack_seq = eof_ack;
            ACK_HIGHEST:       result.ack_seq = highest_reg;
            ACK_HIGHEST_PLUS1: result.ack_seq = highest_reg + SEQ_W'(1);
            default:           result.ack_seq = '0;
        endcase
        case (cmd.slot_sel)
            SLOT_STORE:    result.slot_index = SLOT_OUT_W'(slot_store);
            SLOT_EXPECTED: result.slot_index = SLOT_OUT_W'(exp_slot_reg);
            default:       result.slot_index = '0;
        endcase
    end

    // Next state
    always_comb
    begin
        expected_next  = expected_reg;
        exp_slot_next  = exp_slot_reg;
        highest_next   = highest_reg;
        eof_seen_next  = eof_seen_reg;
        done_next      = done_reg;
        tcount_next    = tcount_reg;
        valid_next     = valid_reg;
        drain_cnt_next = drain_cnt_reg;
        eof_cnt_next   = eof_cnt_reg;
        wsize_next     = wsize_reg;
        tlim_next      = tlim_reg;

        if (cmd.exp_inc)
        begin
            expected_next = expected_reg + SEQ_W'(1);
            exp_slot_next = exp_slot_inc;
        end
        if (cmd.upd_highest && (item_reg.pkt_seq > highest_reg))
        begin
            highest_next = item_reg.pkt_seq;
        end
        if (cmd.set_eof)
        begin
            eof_seen_next = 1'b1;
        end
        if (cmd.set_done)
        begin
            done_next = 1'b1;
        end
        if (cmd.clr_timeout)
        begin
            tcount_next = '0;
        end
        else if (cmd.inc_timeout)
        begin
            tcount_next = tcount_inc;
        end
        if (cmd.store_slot)
        begin
            valid_next[slot_store] = 1'b1;
        end
        // A slot whose tag does not match stays buffered.
        if (cmd.release_slot && tag_hit)
        begin
            valid_next[exp_slot_reg] = 1'b0;
        end
        if (cmd.drain_clr)
        begin
            drain_cnt_next = '0;
        end
        else if (cmd.drain_inc)
        begin
            drain_cnt_next = drain_cnt_reg + DRAIN_W'(1);
        end
        if (cmd.eof_clr)
        begin
            eof_cnt_next = '0;
        end
        else if (cmd.eof_inc)
        begin
            eof_cnt_next = eof_cnt_reg + EOF_W'(1);
        end
        if (cfg_wr)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:   wsize_next = WSIZE_W'(cfg_data);
                REG_TIMEOUT_LIMIT: tlim_next  = TLIM_W'(cfg_data);
                default:           wsize_next = wsize_reg;
            endcase
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            exp_slot_reg  <= '0;
            highest_reg   <= '0;
            eof_seen_reg  <= 1'b0;
            done_reg      <= 1'b0;
            tcount_reg    <= '0;
            valid_reg     <= '0;
            drain_cnt_reg <= '0;
            eof_cnt_reg   <= '0;
            wsize_reg     <= WSIZE_RESET;
            tlim_reg      <= TLIM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg  <= expected_next;
            exp_slot_reg  <= exp_slot_next;
            highest_reg   <= highest_next;
            eof_seen_reg  <= eof_seen_next;
            done_reg      <= done_next;
            tcount_reg    <= tcount_next;
            valid_reg     <= valid_next;
            drain_cnt_reg <= drain_cnt_next;
            eof_cnt_reg   <= eof_cnt_next;
            wsize_reg     <= wsize_next;
            tlim_reg      <= tlim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_emit_only_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free
    ) else $error("result loaded while the previous one is still stalled");

    a_store_sets_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.store_slot |=> valid_reg[$past(slot_store)]
    ) else $error("stored slot not marked valid");

    a_expected_steps_by_one: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.exp_inc |=> (expected_reg == $past(expected_reg) + SEQ_W'(1))
    ) else $error("expected sequence did not advance by one");

    a_done_sticky: assert property (
        @(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg
    ) else $error("finished flag cleared");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for selective_reject_receiver_unit. A short table of
// directed steps is followed by random packet sequences under four flow
// control phases. Every transfer out of the unit is compared field by field
// with the table's commands for typed steps, else with what the model predicts.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srr_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 70;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;

    localparam logic [KIND_W-1:0] KIND_OTHER = KIND_EOF + KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_MAX   = '1;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t              item;
        logic                  typed;
        logic [1:0]            n_typed;
        out_item_t             first;
        out_item_t             second;
    } step_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Receiver state as the commands imply it
    logic [WSIZE_W-1:0] win_reg    = WSIZE_RESET;
    logic [TLIM_W-1:0]  tlim_reg   = TLIM_RESET;
    logic [SEQ_W-1:0]   next_seq   = '0;
    logic [SEQ_W-1:0]   top_seq    = '0;
    logic               eof_flag   = 1'b0;
    logic               finished   = 1'b0;
    logic [TLIM_W-1:0]  tick_count = '0;
    logic               slot_full [WINDOW_DEPTH];
    logic [SEQ_W-1:0]   slot_seq  [WINDOW_DEPTH];

    out_item_t pending_cmds[$];
    out_item_t step_cmds[$];
    step_row_t steps[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int offered        = 0;
    int mismatches     = 0;
    int cycles         = 0;

    selective_reject_receiver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // A long hold-off lets the unit fill up and push back on its input.
    always @(posedge clk)
    begin
        if (hold_reqs != hold_taken)
        begin
            hold_taken = hold_reqs;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_cmds
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("cycle %0d: unexpected command cmd=%0d seq=%h slot=%0d last=%0b",
                             cycles, out_data.command, out_data.ack_seq,
                             out_data.slot_index, out_data.last);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (out_data.command !== want.command || out_data.ack_seq !== want.ack_seq ||
                    out_data.slot_index !== want.slot_index || out_data.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("cycle %0d: expected cmd=%0d seq=%h slot=%0d last=%0b,",
                                 cycles, want.command, want.ack_seq, want.slot_index,
                                 want.last);
                        $display("    got cmd=%0d seq=%h slot=%0d last=%0b",
                                 out_data.command, out_data.ack_seq,
                                 out_data.slot_index, out_data.last);
                    end
                end
            end
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    function automatic out_item_t mk_cmd(command_t c, logic [SEQ_W-1:0] s,
                                         logic [SLOT_OUT_W-1:0] sl, logic l);
        out_item_t r;
        r.command    = c;
        r.ack_seq    = s;
        r.slot_index = sl;
        r.last       = l;
        return r;
    endfunction

    function automatic in_item_t pkt(logic [SEQ_W-1:0] s, logic [KIND_W-1:0] k,
                                     logic g, logic p);
        in_item_t r;
        r.action        = ACTION_PACKET;
        r.pkt_seq       = s;
        r.pkt_kind      = k;
        r.checksum_good = g;
        r.has_payload   = p;
        return r;
    endfunction

    // The packet fields of a timeout tick carry junk that must be ignored.
    function automatic in_item_t tick(logic [SEQ_W-1:0] s, logic [KIND_W-1:0] k,
                                      logic g, logic p);
        in_item_t r;
        r        = pkt(s, k, g, p);
        r.action = ACTION_TIMEOUT;
        return r;
    endfunction

    function automatic in_item_t junk_tick();
        return tick($urandom(), KIND_W'($urandom()), coin(), coin());
    endfunction

    function automatic logic [KIND_W-1:0] data_kind();
        return KIND_W'($urandom_range(KIND_TIMEOUT_RESEND));
    endfunction

    function automatic logic [SEQ_W-1:0] window_span();
        if (win_reg == 0)
            return 1;
        if (win_reg > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return SEQ_W'(win_reg);
    endfunction

    task automatic push_cmd(command_t c, logic [SEQ_W-1:0] s, logic [SLOT_OUT_W-1:0] sl);
        step_cmds.push_back(mk_cmd(c, s, sl, 1'b0));
    endtask

    task automatic predict_commands(in_item_t it);
        int        s;
        int        drained;
        logic [SEQ_W-1:0] ack;
        out_item_t tail;
        step_cmds.delete();
        if (!finished)
        begin
            if (it.action == ACTION_TIMEOUT)
            begin
                if (eof_flag)
                begin
                    push_cmd(CMD_FINISHED, '0, '0);
                    finished = 1'b1;
                end
                else
                begin
                    push_cmd(CMD_RR, top_seq, '0);
                    if (tick_count != '1)
                        tick_count++;
                    if (tick_count >= tlim_reg)
                    begin
                        push_cmd(CMD_SREJ, top_seq + 1, '0);
                        push_cmd(CMD_FINISHED, '0, '0);
                        finished = 1'b1;
                    end
                end
            end
            else if (!it.checksum_good)
                push_cmd(CMD_SREJ, next_seq, '0);
            else
            begin
                tick_count = '0;
                if (it.pkt_kind <= KIND_TIMEOUT_RESEND)
                begin
                    if (it.pkt_seq == next_seq)
                    begin
                        s = it.pkt_seq % WINDOW_DEPTH;
                        if (slot_full[s] && slot_seq[s] == it.pkt_seq)
                            slot_full[s] = 1'b0;
                        push_cmd(CMD_WRITE_IN, it.pkt_seq, '0);
                        push_cmd(CMD_RR, it.pkt_seq, '0);
                        next_seq++;
                        drained = 0;
                        s = next_seq % WINDOW_DEPTH;
                        while (drained < DRAIN_MAX && slot_full[s] && slot_seq[s] == next_seq)
                        begin
                            push_cmd(CMD_WRITE_SLOT, next_seq, SLOT_OUT_W'(s));
                            push_cmd(CMD_RR, next_seq, '0);
                            slot_full[s] = 1'b0;
                            next_seq++;
                            drained++;
                            s = next_seq % WINDOW_DEPTH;
                        end
                    end
                    else if (it.pkt_seq > next_seq)
                    begin
                        if (it.pkt_seq - next_seq <= window_span())
                        begin
                            s = it.pkt_seq % WINDOW_DEPTH;
                            slot_full[s] = 1'b1;
                            slot_seq[s]  = it.pkt_seq;
                            push_cmd(CMD_STORE, it.pkt_seq, SLOT_OUT_W'(s));
                        end
                        push_cmd(CMD_SREJ, next_seq, '0);
                    end
                    else if (next_seq != 0)
                        push_cmd(CMD_RR, next_seq - 1, '0);
                end
                else if (it.pkt_kind == KIND_EOF)
                begin
                    ack = (next_seq != 0) ? next_seq - 1 : '0;
                    if (it.has_payload)
                        push_cmd(CMD_WRITE_IN, it.pkt_seq, '0);
                    repeat (EOF_REPEAT) push_cmd(CMD_RR, ack, '0);
                    push_cmd(CMD_FINISHED, '0, '0);
                    eof_flag = 1'b1;
                    finished = 1'b1;
                end
                if (it.pkt_seq > top_seq)
                    top_seq = it.pkt_seq;
            end
        end
        if (step_cmds.size() != 0)
        begin
            tail = step_cmds.pop_back();
            tail.last = 1'b1;
            step_cmds.push_back(tail);
        end
    endtask

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer(in_item_t it);
        send_item(it);
        predict_commands(it);
        foreach (step_cmds[i])
            pending_cmds.push_back(step_cmds[i]);
        offered++;
    endtask

    // An item may produce nothing, so keep waiting for a settling time beyond the
    // last expected command before the unit is considered idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_SIZE)
            win_reg = val[WSIZE_W-1:0];
        else
            tlim_reg = val;
        @(posedge clk);
    endtask

    task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        step_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        steps.push_back(r);
    endtask

    task automatic add_pkt(in_item_t it);
        step_row_t r;
        r      = '0;
        r.item = it;
        steps.push_back(r);
    endtask

    task automatic add_typed(in_item_t it, int n, out_item_t a, out_item_t b);
        step_row_t r;
        r         = '0;
        r.item    = it;
        r.typed   = 1'b1;
        r.n_typed = 2'(n);
        r.first   = a;
        r.second  = b;
        steps.push_back(r);
    endtask

    // Out-of-order arrivals ahead of the expected sequence, then the missing
    // packet that closes the gap and releases the buffered ones.
    task automatic play_gap_fill();
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] order[$];
        int               k;
        logic             full_fill;
        base      = next_seq;
        k         = $urandom_range(1, window_span());
        full_fill = ($urandom_range(3) == 0);
        if (full_fill)
            k = window_span();
        for (int i = 1; i <= k; i++)
        begin
            if (full_fill || $urandom_range(4) != 0)
            begin
                if ($urandom_range(1))
                    order.push_back(base + i);
                else
                    order.push_front(base + i);
            end
        end
        foreach (order[j])
        begin
            if ($urandom_range(9) == 0)
                offer(pkt(order[j], data_kind(), 1'b0, coin()));
            offer(pkt(order[j], data_kind(), 1'b1, coin()));
        end
        offer(pkt(base, data_kind(), 1'b1, coin()));
        if ($urandom_range(1))
            offer(pkt(next_seq, data_kind(), 1'b1, coin()));
    endtask

    task automatic play_noise();
        in_item_t it;
        it.action        = ACTION_PACKET;
        it.pkt_kind      = KIND_W'($urandom());
        it.checksum_good = ($urandom_range(4) != 0);
        it.has_payload   = coin();
        case ($urandom_range(2))
            0: it.pkt_seq = $urandom();
            1: it.pkt_seq = next_seq - $urandom_range(1, 6);
            default: it.pkt_seq = next_seq + $urandom_range(1, 40);
        endcase
        // A good EOF would end the transfer for the rest of the run.
        if (it.checksum_good && it.pkt_kind == KIND_EOF)
            it.checksum_good = 1'b0;
        offer(it);
    endtask

    task automatic play_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            play_gap_fill();
        else if (pick < 60)
            repeat ($urandom_range(1, 6))
                offer(pkt(next_seq, data_kind(), 1'b1, coin()));
        else if (pick < 75)
            play_noise();
        else if (pick < 88)
        begin
            // Only tick while the count stays below the give-up limit.
            if (tick_count + 1 < tlim_reg)
                offer(junk_tick());
            else
                play_noise();
        end
        else
            offer(pkt($urandom(), KIND_W'($urandom()), 1'b0, coin()));
    endtask

    initial
    begin
        step_row_t row;
        int        start;
        logic      paused;
        int        ending;

        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            slot_full[i] = 1'b0;
            slot_seq[i]  = '0;
        end

        add_reg(REG_WINDOW_SIZE, 8'hFF);
        add_reg(REG_TIMEOUT_LIMIT, 8'd255);
        add_typed(pkt(0, KIND_DATA, 1'b1, 1'b1), 2,
                  mk_cmd(CMD_WRITE_IN, 0, 0, 1'b0), mk_cmd(CMD_RR, 0, 0, 1'b1));
        add_typed(pkt(32'hFFFF_FFFF, KIND_MAX, 1'b0, 1'b1), 1,
                  mk_cmd(CMD_SREJ, 1, 0, 1'b1), '0);
        add_pkt(pkt(3, KIND_DATA, 1'b1, 1'b0));
        add_pkt(pkt(2, KIND_SREJ_RESEND, 1'b1, 1'b1));
        add_pkt(pkt(17, KIND_TIMEOUT_RESEND, 1'b1, 1'b0));
        add_pkt(pkt(1, KIND_DATA, 1'b1, 1'b1));
        add_typed(pkt(0, KIND_DATA, 1'b1, 1'b0), 1, mk_cmd(CMD_RR, 3, 0, 1'b1), '0);
        add_typed(pkt(32'h8000_0000, KIND_OTHER, 1'b1, 1'b1), 0, '0, '0);
        add_typed(tick(32'h5A5A_A5A5, KIND_MAX, 1'b0, 1'b1), 1,
                  mk_cmd(CMD_RR, 32'h8000_0000, 0, 1'b1), '0);
        add_typed(pkt(21, KIND_DATA, 1'b1, 1'b0), 1, mk_cmd(CMD_SREJ, 4, 0, 1'b1), '0);
        add_reg(REG_WINDOW_SIZE, 8'd0);
        add_pkt(pkt(6, KIND_DATA, 1'b1, 1'b1));
        add_pkt(pkt(5, KIND_SREJ_RESEND, 1'b1, 1'b0));
        add_typed(pkt(3, KIND_EOF, 1'b0, 1'b1), 1, mk_cmd(CMD_SREJ, 4, 0, 1'b1), '0);
        add_reg(REG_WINDOW_SIZE, 8'd16);
        add_pkt(pkt(20, KIND_DATA, 1'b1, 1'b1));
        add_pkt(pkt(4, KIND_DATA, 1'b1, 1'b0));
        add_typed(pkt(36, KIND_MAX, 1'b1, 1'b0), 0, '0, '0);
        add_reg(REG_TIMEOUT_LIMIT, 8'd2);
        add_typed(tick(32'h0, KIND_DATA, 1'b1, 1'b0), 1,
                  mk_cmd(CMD_RR, 32'h8000_0000, 0, 1'b1), '0);
        add_pkt(pkt(6, KIND_TIMEOUT_RESEND, 1'b1, 1'b1));
        add_typed(tick(32'hFFFF_FFFF, KIND_EOF, 1'b1, 1'b1), 1,
                  mk_cmd(CMD_RR, 32'h8000_0000, 0, 1'b1), '0);
        add_typed(pkt(1, KIND_DATA, 1'b1, 1'b0), 1, mk_cmd(CMD_RR, 6, 0, 1'b1), '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[r])
        begin
            row = steps[r];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end
            else if (!row.typed)
                offer(row.item);
            else
            begin
                send_item(row.item);
                predict_commands(row.item);
                if (row.n_typed >= 1)
                    pending_cmds.push_back(row.first);
                if (row.n_typed == 2)
                    pending_cmds.push_back(row.second);
            end
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_reg(REG_WINDOW_SIZE, 8'd16);
                    write_reg(REG_TIMEOUT_LIMIT, 8'd255);
                end
                1:
                begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                    write_reg(REG_WINDOW_SIZE, 8'd1);
                    write_reg(REG_TIMEOUT_LIMIT, 8'd3);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'($urandom()));
                    write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'($urandom_range(2, 254)));
                    hold_reqs++;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                    write_reg(REG_WINDOW_SIZE, 8'd16);
                    write_reg(REG_TIMEOUT_LIMIT, 8'd255);
                end
            endcase
            start  = offered;
            paused = 1'b0;
            while (offered - start < PHASE_ITEMS)
            begin
                play_sequence();
                if (phase == 1 && !paused && offered - start >= PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        // Close the transfer one way or another, then show that the unit
        // ignores everything that follows.
        settle();
        if ($urandom_range(1))
            offer(pkt(32'hFFFF_FFFF, KIND_OTHER, 1'b1, 1'b1));
        ending = $urandom_range(3);
        case (ending)
            0, 1: offer(pkt($urandom(), KIND_EOF, 1'b1, ending == 0));
            2:
            begin
                settle();
                write_reg(REG_TIMEOUT_LIMIT, 8'd0);
                offer(junk_tick());
            end
            default:
            begin
                settle();
                write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'($urandom_range(1, 4)));
                while (!finished)
                    offer(junk_tick());
            end
        endcase
        repeat (6)
        begin
            if ($urandom_range(1))
                offer(junk_tick());
            else
                offer(pkt($urandom(), KIND_W'($urandom()), coin(), coin()));
        end
        settle();
        write_reg(REG_WINDOW_SIZE, CFG_DATA_W'($urandom()));
        repeat (4) offer(pkt(next_seq, KIND_EOF, 1'b1, 1'b1));
        settle();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
